@@ hw/rtl/hpr_pkg.sv @@
// Package for the hello packet receive checker: types, constants, codes.
`default_nettype none
package hpr_pkg;

    localparam int TableDepth = 16;
    localparam int SlotW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
    localparam int CntW = $clog2(TableDepth + 1);
    localparam logic [7:0] EbitMask = 8'h02;

    localparam logic [2:0] CFG_OWN_RID = 3'd0;
    localparam logic [2:0] CFG_AREA    = 3'd1;
    localparam logic [2:0] CFG_NET     = 3'd2;
    localparam logic [2:0] CFG_MASK    = 3'd3;
    localparam logic [2:0] CFG_HELLO   = 3'd4;
    localparam logic [2:0] CFG_DEAD    = 3'd5;
    localparam logic [2:0] CFG_MODE    = 3'd6;
    localparam logic [2:0] CFG_IFST    = 3'd7;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_AREA   = 3'd1;
    localparam logic [2:0] ST_SUBNET = 3'd2;
    localparam logic [2:0] ST_MASK   = 3'd3;
    localparam logic [2:0] ST_HELLO  = 3'd4;
    localparam logic [2:0] ST_DEAD   = 3'd5;
    localparam logic [2:0] ST_OPT    = 3'd6;
    localparam logic [2:0] ST_FULL   = 3'd7;

    localparam logic [1:0] IFS_WAITING = 2'd1;
    localparam logic [1:0] WAY_NONE = 2'd0;
    localparam logic [1:0] WAY_ONE  = 2'd1;
    localparam logic [1:0] WAY_TWO  = 2'd2;
    localparam logic [1:0] IEV_NONE   = 2'd0;
    localparam logic [1:0] IEV_CHANGE = 2'd1;
    localparam logic [1:0] IEV_BACKUP = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [31:0] pkt_area;
        logic [31:0] src_ip;
        logic [31:0] router_word;
        logic [31:0] pkt_mask;
        logic [15:0] pkt_hello;
        logic [31:0] pkt_dead;
        logic [7:0]  pkt_options;
        logic [7:0]  pkt_priority;
        logic [31:0] pkt_dr;
        logic [31:0] pkt_bdr;
        logic        last;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] status;
        logic       new_neighbor;
        logic [3:0] neighbor_slot;
        logic       hello_event;
        logic [1:0] way_event;
        logic [1:0] iface_event;
    } out_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture header beat, run checks
        logic list_cmp;  // compare list word with own ID
        logic scan_clr;  // reset search index
        logic scan_step; // examine one table slot
        logic update;    // write the sender entry, compute events
        logic emit;      // drive the result beat
        logic close;     // clear packet-open
    } hpr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic open;
        logic hdr_ok;
        logic scan_done;
    } hpr_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/hpr_ctrl.sv @@
// Controller state machine for the hello packet receive checker.
`default_nettype none
module hpr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            kind,
    input  wire logic            last,
    input  hpr_pkg::hpr_stat_t   stat,
    output logic                 busy,
    output hpr_pkg::hpr_cmd_t    cmd
);
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_UPDATE = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        busy       = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    last_next = last;
                    if (!kind)
                    begin
                        cmd.load     = 1'b1;
                        cmd.scan_clr = 1'b1;
                        state_next   = S_CHECK;
                    end
                    else if (stat.open)
                    begin
                        cmd.list_cmp = 1'b1;
                        if (last)
                            state_next = S_EMIT;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.hdr_ok)
                    state_next = S_SCAN;
                else
                    state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                cmd.close  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/hpr_dpath.sv @@
// Datapath: header checks, neighbor table, event logic, result register.
`default_nettype none
module hpr_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  hpr_pkg::in_beat_t      in_beat,
    input  hpr_pkg::hpr_cmd_t      cmd,
    output hpr_pkg::hpr_stat_t     stat,
    output logic                   done,
    output hpr_pkg::out_beat_t     res
);
    localparam int SW = hpr_pkg::SlotW;
    localparam int CW = hpr_pkg::CntW;
    localparam int D  = hpr_pkg::TableDepth;

    // configuration registers
    logic [31:0] own_rid_reg, area_reg, net_reg, mask_reg, dead_reg;
    logic [15:0] hello_reg;
    logic [1:0]  mode_reg, ifst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_rid_reg <= '0;
            area_reg    <= '0;
            net_reg     <= '0;
            mask_reg    <= 32'hFFFF_FF00;
            hello_reg   <= 16'd10;
            dead_reg    <= 32'd40;
            mode_reg    <= 2'd1;
            ifst_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hpr_pkg::CFG_OWN_RID: own_rid_reg <= cfg_data;
                hpr_pkg::CFG_AREA:    area_reg    <= cfg_data;
                hpr_pkg::CFG_NET:     net_reg     <= cfg_data;
                hpr_pkg::CFG_MASK:    mask_reg    <= cfg_data;
                hpr_pkg::CFG_HELLO:   hello_reg   <= cfg_data[15:0];
                hpr_pkg::CFG_DEAD:    dead_reg    <= cfg_data;
                hpr_pkg::CFG_MODE:    mode_reg    <= cfg_data[1:0];
                hpr_pkg::CFG_IFST:    ifst_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // header capture
    logic [31:0] src_reg, rid_reg, pdr_reg, pbdr_reg;
    logic [7:0]  prio_reg;
    logic [2:0]  status_reg, status_next;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg  <= in_beat.src_ip;
            rid_reg  <= in_beat.router_word;
            pdr_reg  <= in_beat.pkt_dr;
            pbdr_reg <= in_beat.pkt_bdr;
            prio_reg <= in_beat.pkt_priority;
        end
    end

    // header checks in priority order
    logic ebit, stub;
    always_comb
    begin
        ebit = (in_beat.pkt_options & hpr_pkg::EbitMask) != 8'd0;
        stub = mode_reg[0];
        if (in_beat.pkt_area != area_reg)
            status_next = hpr_pkg::ST_AREA;
        else if ((in_beat.src_ip & mask_reg) != (net_reg & mask_reg))
            status_next = hpr_pkg::ST_SUBNET;
        else if (mode_reg[1] && in_beat.pkt_mask != mask_reg)
            status_next = hpr_pkg::ST_MASK;
        else if (in_beat.pkt_hello != hello_reg)
            status_next = hpr_pkg::ST_HELLO;
        else if (in_beat.pkt_dead != dead_reg)
            status_next = hpr_pkg::ST_DEAD;
        else if (ebit == stub)
            status_next = hpr_pkg::ST_OPT;
        else
            status_next = hpr_pkg::ST_OK;
    end

    // neighbor table: valid bits in flops, payload arrays indexed by one slot
    logic [D-1:0] valid_reg;
    logic [31:0]  ip_mem [D];
    logic [31:0]  rid_mem [D];
    logic [7:0]   prio_mem [D];
    logic [31:0]  dr_mem [D];
    logic [31:0]  bdr_mem [D];

    // sequential search, one slot per cycle
    logic [CW-1:0] idx_reg;
    logic [SW-1:0] hit_reg, free_reg, cur_slot_reg;
    logic          hit_ok_reg, free_ok_reg;
    logic [SW-1:0] idx_s;
    assign idx_s = idx_reg[SW-1:0];
    assign stat.scan_done = (idx_reg == CW'(D - 1)) ||
                            (valid_reg[idx_s] && ip_mem[idx_s] == src_reg);

    // packet flags
    logic open_reg, found_reg, new_reg, prev_reg;
    logic [1:0] ev_reg;
    assign stat.open   = open_reg;
    assign stat.hdr_ok = (status_reg == hpr_pkg::ST_OK);

    // sender slot and its old values
    logic          hit_now, free_now, have_hit, have_free;
    logic [SW-1:0] slot;
    logic          is_new;
    logic [7:0]    o_prio;
    logic [31:0]   o_dr, o_bdr;
    logic          waiting, prio_ch, prev_dr, dr_ch, prev_bdr, bdr_ch;
    logic          dr_self, bdr_self;
    logic [1:0]    ev;

    always_comb
    begin
        hit_now   = valid_reg[idx_s] && ip_mem[idx_s] == src_reg;
        free_now  = !valid_reg[idx_s];
        have_hit  = hit_ok_reg;
        have_free = free_ok_reg;
        slot = free_reg;
        is_new = 1'b1;
        if (have_hit)
        begin
            slot = hit_reg;
            is_new = 1'b0;
        end
        o_prio = is_new ? 8'd0  : prio_mem[slot];
        o_dr   = is_new ? 32'd0 : dr_mem[slot];
        o_bdr  = is_new ? 32'd0 : bdr_mem[slot];
        waiting  = (ifst_reg == hpr_pkg::IFS_WAITING);
        prio_ch  = (o_prio != prio_reg);
        prev_dr  = (o_dr == src_reg);
        dr_ch    = (o_dr != pdr_reg);
        prev_bdr = (o_bdr == src_reg);
        bdr_ch   = (o_bdr != pbdr_reg);
        dr_self  = (pdr_reg == src_reg);
        bdr_self = (pbdr_reg == src_reg);
        ev = prio_ch ? hpr_pkg::IEV_CHANGE : hpr_pkg::IEV_NONE;
        if (pbdr_reg == 32'd0 && waiting && dr_self)
            ev = hpr_pkg::IEV_BACKUP;
        else if (dr_self && dr_ch)
            ev = hpr_pkg::IEV_CHANGE;
        else if (!dr_self && prev_dr)
            ev = hpr_pkg::IEV_CHANGE;
        if (waiting && bdr_self)
            ev = hpr_pkg::IEV_BACKUP;
        else if (bdr_self && bdr_ch)
            ev = hpr_pkg::IEV_CHANGE;
        else if (!bdr_self && prev_bdr)
            ev = hpr_pkg::IEV_CHANGE;
    end

    // result beat contents
    hpr_pkg::out_beat_t res_next;
    always_comb
    begin
        res_next = '0;
        res_next.status = status_reg;
        if (status_reg == hpr_pkg::ST_OK)
        begin
            res_next.new_neighbor  = new_reg;
            res_next.neighbor_slot = 4'(cur_slot_reg);
            res_next.hello_event   = 1'b1;
            res_next.way_event     = found_reg ? hpr_pkg::WAY_TWO : hpr_pkg::WAY_ONE;
            res_next.iface_event   = (found_reg || prev_reg) ? ev_reg
                                                             : hpr_pkg::IEV_NONE;
        end
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            open_reg     <= 1'b0;
            found_reg    <= 1'b0;
            new_reg      <= 1'b0;
            prev_reg     <= 1'b0;
            ev_reg       <= '0;
            status_reg   <= '0;
            cur_slot_reg <= '0;
            idx_reg      <= '0;
            hit_ok_reg   <= 1'b0;
            free_ok_reg  <= 1'b0;
            hit_reg      <= '0;
            free_reg     <= '0;
            done         <= 1'b0;
            res          <= '0;
        end
        else
        begin
            done <= cmd.emit;
            if (cmd.load)
            begin
                open_reg     <= 1'b1;
                found_reg    <= 1'b0;
                new_reg      <= 1'b0;
                prev_reg     <= 1'b0;
                ev_reg       <= '0;
                cur_slot_reg <= '0;
                status_reg   <= status_next;
            end
            if (cmd.list_cmp && in_beat.router_word == own_rid_reg)
                found_reg <= 1'b1;
            if (cmd.scan_clr)
            begin
                idx_reg     <= '0;
                hit_ok_reg  <= 1'b0;
                free_ok_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + CW'(1);
                if (hit_now && !hit_ok_reg)
                begin
                    hit_ok_reg <= 1'b1;
                    hit_reg    <= idx_s;
                end
                if (free_now && !free_ok_reg)
                begin
                    free_ok_reg <= 1'b1;
                    free_reg    <= idx_s;
                end
            end
            if (cmd.update)
            begin
                if (!have_hit && !have_free)
                    status_reg <= hpr_pkg::ST_FULL;
                else
                begin
                    valid_reg[slot] <= 1'b1;
                    cur_slot_reg    <= slot;
                    new_reg         <= is_new;
                    ev_reg          <= ev;
                    prev_reg        <= prev_dr || prev_bdr;
                end
            end
            if (cmd.emit)
                res <= res_next;
            if (cmd.close)
                open_reg <= 1'b0;
        end
    end

    // table payload writes
    always_ff @(posedge clk)
    begin
        if (cmd.update && (have_hit || have_free))
        begin
            ip_mem[slot]   <= src_reg;
            rid_mem[slot]  <= rid_reg;
            prio_mem[slot] <= prio_reg;
            dr_mem[slot]   <= pdr_reg;
            bdr_mem[slot]  <= pbdr_reg;
        end
    end

    logic unused_rid;
    assign unused_rid = ^rid_mem[cur_slot_reg];
endmodule
`default_nettype wire

@@ hw/rtl/hello_packet_receive_checker.sv @@
// Top level of the hello packet receive checker.
// Use: pulse start with a beat on item while busy is low. A packet is one
// header beat (kind 0) then listed-neighbor beats (kind 1), the final one
// marked by last. The header check result is registered; an accepted header
// then searches the neighbor table one slot per cycle, stopping at a match
// or at the last of its 16 slots, and then writes the sender entry. A list
// beat is taken in the cycle it arrives and holds busy only through the
// emit state when it is the final beat; a final header beat also passes
// through the emit state. The result is driven on result with done high
// for exactly one cycle, right after the emit cycle; the receiver cannot
// stall, so results are never held.
// List beats with no open packet are dropped; a header while a packet is
// open restarts the packet. Reset clears the table valid bits at once and
// loads register defaults. Configuration: cfg_we/cfg_index/cfg_data,
// taken on any edge with cfg_we high; the user must write it only while the
// block is idle, which the block itself does not enforce.
`default_nettype none
module hello_packet_receive_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  hpr_pkg::in_beat_t      item,
    output logic                   done,
    output hpr_pkg::out_beat_t     result,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);
    hpr_pkg::hpr_cmd_t  cmd;
    hpr_pkg::hpr_stat_t stat;

    hpr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .kind(item.kind),
        .last(item.last), .stat(stat), .busy(busy), .cmd(cmd)
    );

    hpr_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_beat(item), .cmd(cmd), .stat(stat),
        .done(done), .res(result)
    );

    // a result beat only follows an emit command
    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.emit)) else $error("result without emit");
    // only one datapath phase at a time
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan_step, cmd.update, cmd.emit}))
        else $error("overlapping commands");
    // a failed check never starts the table scan
    a_no_update_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> stat.hdr_ok) else $error("scan on rejected header");
endmodule
`default_nettype wire
